FILE: src/momentum_quadratic_fit_step_core_defines.svh
// Assertion macros for the momentum quadratic fit core.
// Used by src/mqf_front.sv and src/mqf_back.sv; expects clk and rst in scope.
`ifndef MOMENTUM_QUADRATIC_FIT_STEP_CORE_DEFINES_SVH
`define MOMENTUM_QUADRATIC_FIT_STEP_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define MQF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define MQF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MQF_ASSERT_IMP(lbl, ante, cons, msg)
`define MQF_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: src/mqf_pkg.sv
// Shared types, constants and arithmetic helpers of the momentum quadratic fit core.
// No dependencies; imported by every module of the block.
`default_nettype none

package mqf_pkg;

  localparam int MAX_BATCH = 128;
  localparam int BCW       = $clog2(MAX_BATCH + 1);
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int QCW       = $clog2(QDEPTH + 1);
  localparam int DIV_STEPS = 48;
  localparam int DCW       = $clog2(DIV_STEPS);

  localparam logic [47:0] LOSS_MAX = 48'hFFFF_FFFF_FFFF;

  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] REG_INITIAL_A       = 3'd0;
  localparam logic [CFG_IW-1:0] REG_INITIAL_B       = 3'd1;
  localparam logic [CFG_IW-1:0] REG_LEARNING_RATE   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_MOMENTUM        = 3'd3;
  localparam logic [CFG_IW-1:0] REG_STEP_LIMIT      = 3'd4;
  localparam logic [CFG_IW-1:0] REG_PERTURBATION    = 3'd5;
  localparam logic [CFG_IW-1:0] REG_STOP_THRESHOLD  = 3'd6;
  localparam logic [CFG_IW-1:0] REG_ITERATION_LIMIT = 3'd7;

  typedef struct packed {
    logic signed [31:0] initial_a;
    logic signed [31:0] initial_b;
    logic [15:0]        learning_rate;
    logic [15:0]        momentum;
    logic [30:0]        step_limit;
    logic [15:0]        perturbation;
    logic [47:0]        stop_threshold;
    logic [15:0]        iteration_limit;
  } mqf_cfg_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
    logic               restart;
  } mqf_item_t;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic [47:0]        batch_loss;
    logic               finished;
  } mqf_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -33'sh0_8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // magnitude of a Q.32 residual rounded half up to Q.16
  function automatic logic [47:0] round_mag(input logic signed [63:0] r);
    logic [63:0] m;
    logic [63:0] s;
    m = r[63] ? 64'(-r) : 64'(r);
    s = m + 64'd32768;
    return s[63:16];
  endfunction

  function automatic logic [47:0] sq_to_loss(input logic [63:0] sq, input logic big);
    logic [48:0] q;
    q = {1'b0, sq[63:16]} + {48'd0, sq[15]};
    if (big || q[48]) return LOSS_MAX;
    return q[47:0];
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? LOSS_MAX : s[47:0];
  endfunction

  // Q.32 velocity to Q.16, ties away from zero, saturated to 32 bits
  function automatic logic signed [31:0] vel_round(input logic signed [51:0] p);
    logic [51:0]        m;
    logic [51:0]        s;
    logic signed [36:0] r;
    m = p[51] ? 52'(-p) : 52'(p);
    s = m + 52'd32768;
    r = $signed({1'b0, s[51:16]});
    if (p[51]) r = -r;
    if (r > 37'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (r < -37'sh0_8000_0000) return -32'sh8000_0000;
    return r[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/mqf_front.sv
// Front end: accepts samples, marks batch ends, and queues them for the back end.
// Depends on mqf_pkg and the assertion macro header.
`default_nettype none
`include "momentum_quadratic_fit_step_core_defines.svh"

module mqf_front
  import mqf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [15:0] sample_x,
  input  wire logic signed [15:0] sample_y,
  input  wire logic               last_in_batch,
  input  wire logic               restart,
  output logic                    q_valid,
  output mqf_item_t               q_item,
  input  wire logic               q_pop
);

  mqf_item_t        mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   cnt;
  logic [BCW-1:0]   bcnt;
  logic [BCW-1:0]   bsum;
  logic             wr_en;
  logic             rd_en;
  logic             is_last;

  assign full    = (cnt == QCW'(QDEPTH));
  assign q_valid = (cnt != '0);
  assign q_item  = mem[rd_ptr];
  assign wr_en   = push && !full;
  assign rd_en   = q_pop && q_valid;
  assign bsum    = (restart ? '0 : bcnt) + BCW'(1);
  assign is_last = last_in_batch || (bsum >= BCW'(MAX_BATCH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= '{x: sample_x, y: sample_y, last: is_last, restart: restart};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
      bcnt   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + QAW'(1);
        bcnt   <= is_last ? '0 : bsum;
      end
      if (rd_en) rd_ptr <= rd_ptr + QAW'(1);
      if (wr_en && !rd_en) cnt <= cnt + QCW'(1);
      else if (!wr_en && rd_en) cnt <= cnt - QCW'(1);
    end
  end

  `MQF_ASSERT_IMP(a_cnt_bound, 1'b1, cnt <= QCW'(QDEPTH), "queue count overflow")
  `MQF_ASSERT_IMP(a_bcnt_bound, 1'b1, bcnt < BCW'(MAX_BATCH), "batch count overflow")
  `MQF_ASSERT_NXT(a_cnt_grow, wr_en && !rd_en, cnt == $past(cnt) + QCW'(1), "queue count lost")

endmodule

`default_nettype wire

FILE: src/mqf_back.sv
// Back end: per-sample loss accumulation and the batch-end momentum update.
// Two shared multipliers and a bit-serial divider; depends on mqf_pkg and the macro header.
`default_nettype none
`include "momentum_quadratic_fit_step_core_defines.svh"

module mqf_back
  import mqf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire mqf_cfg_t  cfg,
  input  wire logic      q_valid,
  input  wire mqf_item_t q_item,
  output logic           q_pop,
  output logic           res_valid,
  output mqf_res_t       res,
  input  wire logic      res_ready
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_M1   = 5'd1;
  localparam logic [4:0] S_M2   = 5'd2;
  localparam logic [4:0] S_M3   = 5'd3;
  localparam logic [4:0] S_M4   = 5'd4;
  localparam logic [4:0] S_RND  = 5'd5;
  localparam logic [4:0] S_SQ1  = 5'd6;
  localparam logic [4:0] S_SQ2  = 5'd7;
  localparam logic [4:0] S_SQ3  = 5'd8;
  localparam logic [4:0] S_GRD  = 5'd9;
  localparam logic [4:0] S_DIV  = 5'd10;
  localparam logic [4:0] S_DEND = 5'd11;
  localparam logic [4:0] S_VEL1 = 5'd12;
  localparam logic [4:0] S_VEL2 = 5'd13;
  localparam logic [4:0] S_VEL3 = 5'd14;
  localparam logic [4:0] S_COEF = 5'd15;
  localparam logic [4:0] S_EMIT = 5'd16;

  logic [4:0]         state;
  logic signed [31:0] coef_a, coef_b, vel_a, vel_b, ga, gb;
  logic [47:0]        loss_base, loss_sa, loss_sb;
  logic [15:0]        iter;
  logic [15:0]        iter_next;
  logic               done;
  logic signed [15:0] x, y;
  logic               last;
  logic [15:0]        dx;
  logic signed [32:0] m0a, m0b, m1a, m1b;
  logic signed [65:0] p0, p1;
  logic signed [63:0] ax_r, bxx_r, dxx_r, r_b, r_sa, r_sb, rb_c;
  logic [31:0]        xx_r;
  logic [31:0]        m16_b, m16_sa, m16_sb;
  logic               big_b, big_sa, big_sb;
  logic               gsel, gneg, gbig;
  logic [15:0]        rem;
  logic [47:0]        quo;
  logic [DCW-1:0]     dcnt;
  logic [47:0]        shifted, dmag;
  logic [16:0]        rem_sh;
  logic               ge;
  logic [47:0]        qv;
  logic signed [31:0] gval;
  logic [47:0]        mb, msa, msb;

  assign dx        = (cfg.perturbation == '0) ? 16'd1 : cfg.perturbation;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign res_valid = (state == S_EMIT);
  assign res       = '{coef_a: coef_a, coef_b: coef_b, batch_loss: loss_base, finished: done};
  assign iter_next = (iter == 16'hFFFF) ? iter : iter + 16'd1;

  always_comb begin
    m0a = '0;
    m0b = '0;
    m1a = '0;
    m1b = '0;
    case (state)
      S_M1: begin
        m0a = {coef_a[31], coef_a};
        m0b = {{17{x[15]}}, x};
        m1a = {{17{x[15]}}, x};
        m1b = {{17{x[15]}}, x};
      end
      S_M2: begin
        m0a = {17'd0, dx};
        m0b = {{17{x[15]}}, x};
        m1a = {coef_b[31], coef_b};
        m1b = {1'b0, p1[31:0]};
      end
      S_M3: begin
        m0a = {17'd0, dx};
        m0b = {1'b0, xx_r};
      end
      S_SQ1: begin
        m0a = {1'b0, m16_b};
        m0b = {1'b0, m16_b};
        m1a = {1'b0, m16_sa};
        m1b = {1'b0, m16_sa};
      end
      S_SQ2: begin
        m0a = {1'b0, m16_sb};
        m0b = {1'b0, m16_sb};
      end
      S_VEL1: begin
        m0a = {17'd0, cfg.momentum};
        m0b = {vel_a[31], vel_a};
        m1a = {17'd0, cfg.learning_rate};
        m1b = {ga[31], ga};
      end
      S_VEL2: begin
        m0a = {17'd0, cfg.momentum};
        m0b = {vel_b[31], vel_b};
        m1a = {17'd0, cfg.learning_rate};
        m1b = {gb[31], gb};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rb_c    = (ax_r <<< 8) + bxx_r - ({{48{y[15]}}, y} <<< 24);
    mb      = round_mag(r_b);
    msa     = round_mag(r_sa);
    msb     = round_mag(r_sb);
    shifted = gsel ? loss_sb : loss_sa;
    dmag    = (shifted < loss_base) ? loss_base - shifted : shifted - loss_base;
    rem_sh  = {rem, quo[47]};
    ge      = rem_sh >= {1'b0, dx};
    qv      = gbig ? {17'd0, cfg.step_limit} : quo;
    if (qv > {17'd0, cfg.step_limit}) qv = {17'd0, cfg.step_limit};
    gval    = gneg ? -$signed({1'b0, qv[30:0]}) : $signed({1'b0, qv[30:0]});
  end

  always_ff @(posedge clk) begin
    p0 <= m0a * m0b;
    p1 <= m1a * m1b;
  end

  always_ff @(posedge clk) begin
    case (state)
      S_M2: begin
        ax_r <= p0[63:0];
        xx_r <= p1[31:0];
      end
      S_M3: begin
        dxx_r <= p0[63:0];
        bxx_r <= p1[63:0];
      end
      S_M4: begin
        r_b  <= rb_c;
        r_sa <= rb_c + (dxx_r <<< 8);
        r_sb <= rb_c + p0[63:0];
      end
      S_RND: begin
        m16_b  <= mb[31:0];
        m16_sa <= msa[31:0];
        m16_sb <= msb[31:0];
        big_b  <= |mb[47:32];
        big_sa <= |msa[47:32];
        big_sb <= |msb[47:32];
      end
      S_GRD: begin
        gneg <= shifted < loss_base;
        gbig <= |dmag[47:32];
        quo  <= {dmag[31:0], 16'd0};
        rem  <= '0;
        dcnt <= '0;
      end
      S_DIV: begin
        rem  <= ge ? 16'(rem_sh - {1'b0, dx}) : rem_sh[15:0];
        quo  <= {quo[46:0], ge};
        dcnt <= dcnt + DCW'(1);
      end
      S_DEND: begin
        if (gsel) gb <= gval;
        else ga <= gval;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      coef_a    <= '0;
      coef_b    <= '0;
      vel_a     <= '0;
      vel_b     <= '0;
      loss_base <= '0;
      loss_sa   <= '0;
      loss_sb   <= '0;
      iter      <= '0;
      done      <= 1'b0;
      gsel      <= 1'b0;
      x         <= '0;
      y         <= '0;
      last      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            x    <= q_item.x;
            y    <= q_item.y;
            last <= q_item.last;
            if (q_item.restart) begin
              coef_a    <= cfg.initial_a;
              coef_b    <= cfg.initial_b;
              vel_a     <= '0;
              vel_b     <= '0;
              loss_base <= '0;
              loss_sa   <= '0;
              loss_sb   <= '0;
              iter      <= '0;
              done      <= 1'b0;
            end
            state <= S_M1;
          end
        end
        S_M1:  state <= S_M2;
        S_M2:  state <= S_M3;
        S_M3:  state <= S_M4;
        S_M4:  state <= S_RND;
        S_RND: state <= S_SQ1;
        S_SQ1: state <= S_SQ2;
        S_SQ2: begin
          loss_base <= sat_add48(loss_base, sq_to_loss(p0[63:0], big_b));
          loss_sa   <= sat_add48(loss_sa, sq_to_loss(p1[63:0], big_sa));
          state     <= S_SQ3;
        end
        S_SQ3: begin
          loss_sb <= sat_add48(loss_sb, sq_to_loss(p0[63:0], big_sb));
          gsel    <= 1'b0;
          if (!last) state <= S_IDLE;
          else if (done) state <= S_EMIT;
          else state <= S_GRD;
        end
        S_GRD: state <= S_DIV;
        S_DIV: begin
          if (dcnt == DCW'(DIV_STEPS - 1)) state <= S_DEND;
        end
        S_DEND: begin
          if (gsel) begin
            state <= S_VEL1;
          end else begin
            gsel  <= 1'b1;
            state <= S_GRD;
          end
        end
        S_VEL1: state <= S_VEL2;
        S_VEL2: begin
          vel_a <= vel_round(p0[51:0] - p1[51:0]);
          state <= S_VEL3;
        end
        S_VEL3: begin
          vel_b <= vel_round(p0[51:0] - p1[51:0]);
          state <= S_COEF;
        end
        S_COEF: begin
          coef_a <= sat32(33'(coef_a) + 33'(vel_a));
          coef_b <= sat32(33'(coef_b) + 33'(vel_b));
          iter   <= iter_next;
          done   <= (loss_base < cfg.stop_threshold) || (iter_next >= cfg.iteration_limit);
          state  <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) begin
            loss_base <= '0;
            loss_sa   <= '0;
            loss_sb   <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MQF_ASSERT_NXT(a_emit_hold, (state == S_EMIT) && !res_ready, state == S_EMIT, "result dropped")
  `MQF_ASSERT_IMP(a_pop_idle, q_pop, state == S_IDLE, "item taken while busy")
  `MQF_ASSERT_NXT(a_frozen, done && (state != S_IDLE), $stable(coef_a) && $stable(vel_a), "frozen coefficient moved")

endmodule

`default_nettype wire

FILE: src/momentum_quadratic_fit_step_core.sv
// Top level of the momentum quadratic fit core: configuration registers,
// front/back instances and the result register. Depends on mqf_pkg, mqf_front, mqf_back.
//
//   channel   handshake        payload
//   sample    push / full      sample_x, sample_y, last_in_batch, restart
//   result    pop / empty      coef_a, coef_b, batch_loss, finished
//   config    cfg_we           cfg_index, cfg_data
//
// A sample passes through the back end in steps: take, three product steps, residual,
// rounding, two squaring steps and the last add, on two shared multipliers.
// A batch end adds two gradients (each a 48-step restoring division) plus velocity,
// coefficient update and emit (just emit once finished); emit waits on a held result.
// The front queue holds 4 samples, so input is taken while the back end works.
// rst is synchronous; it loads register reset values and zero coefficients.
// A result waits in the output register until popped; the back end stalls behind it.
`default_nettype none

module momentum_quadratic_fit_step_core
  import mqf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic signed [15:0]  sample_x,
  input  wire logic signed [15:0]  sample_y,
  input  wire logic                last_in_batch,
  input  wire logic                restart,
  output logic                     empty,
  input  wire logic                pop,
  output logic signed [31:0]       coef_a,
  output logic signed [31:0]       coef_b,
  output logic [47:0]              batch_loss,
  output logic                     finished,
  input  wire logic                cfg_we,
  input  wire logic [CFG_IW-1:0]   cfg_index,
  input  wire logic [47:0]         cfg_data
);

  mqf_cfg_t  cfg;
  mqf_item_t q_item;
  mqf_res_t  res;
  logic      q_valid;
  logic      q_pop;
  logic      res_valid;
  logic      res_ready;
  logic      out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_a       <= '0;
      cfg.initial_b       <= '0;
      cfg.learning_rate   <= 16'd655;
      cfg.momentum        <= 16'd6554;
      cfg.step_limit      <= 31'd327680;
      cfg.perturbation    <= 16'd655;
      cfg.stop_threshold  <= 48'd655;
      cfg.iteration_limit <= 16'd50000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INITIAL_A:       cfg.initial_a       <= cfg_data[31:0];
        REG_INITIAL_B:       cfg.initial_b       <= cfg_data[31:0];
        REG_LEARNING_RATE:   cfg.learning_rate   <= cfg_data[15:0];
        REG_MOMENTUM:        cfg.momentum        <= cfg_data[15:0];
        REG_STEP_LIMIT:      cfg.step_limit      <= cfg_data[30:0];
        REG_PERTURBATION:    cfg.perturbation    <= cfg_data[15:0];
        REG_STOP_THRESHOLD:  cfg.stop_threshold  <= cfg_data;
        REG_ITERATION_LIMIT: cfg.iteration_limit <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  mqf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .sample_x      (sample_x),
    .sample_y      (sample_y),
    .last_in_batch (last_in_batch),
    .restart       (restart),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  mqf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !out_valid || pop;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      coef_a     <= res.coef_a;
      coef_b     <= res.coef_b;
      batch_loss <= res.batch_loss;
      finished   <= res.finished;
    end
  end

endmodule

`default_nettype wire
